### hdl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg - shared types and constants of the cubic spline segment evaluator
// Field widths, opcodes, sequencer states and the multiplier request and
// response records.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int DATA_W = 32;    // Q16.16 fields and results
  localparam int WIDE_W = 64;    // saturating intermediates
  localparam int PROD_W = 128;   // full product of two intermediates
  localparam int HALF_W = 32;    // multiplier slice
  localparam int IDX_W  = 6;     // table index field
  localparam int OP_W   = 2;
  localparam int CNT_W  = 7;     // point_count register

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int MIN_POINTS     = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd2;

  localparam logic [WIDE_W-1:0] MAX64 = {1'b0, {(WIDE_W-1){1'b1}}};
  localparam logic [WIDE_W-1:0] MIN64 = {1'b1, {(WIDE_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_WR_KNOT = 2'd0,
    OP_WR_COEF = 2'd1,
    OP_EVAL    = 2'd2
  } op_t;

  // top level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CMP_FIRST,
    ST_RD_LAST,
    ST_CMP_LAST,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_SEG_RD,
    ST_TAU,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DELIVER
  } st_t;

  // product steps, in issue order
  typedef enum logic [2:0] {
    UOP_T2, // tau^2
    UOP_T3, // tau^3
    UOP_P1, // pos = c0 + c1*tau
    UOP_P2, // pos += c2*tau^2
    UOP_P3, // pos += c3*tau^3
    UOP_V1, // vel = c1 + 2c2*tau
    UOP_V2, // vel += 3c3*tau^2
    UOP_A1  // acc = 2c2 + 6c3*tau
  } uop_t;

  // multiplier sequencer
  typedef enum logic [2:0] {
    M_IDLE,
    M_ABS,
    M_PP,
    M_ROUND,
    M_SAT
  } mul_st_t;

  typedef struct packed {
    logic              start;
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [WIDE_W-1:0] result;
  } mul_rsp_t;

endpackage

### hdl/cse_in_if.sv
// ----------------------------------------------------------------------------
// cse_in_if - command channel of the spline evaluator
// Valid/ready channel carrying table writes and evaluate requests.
// ----------------------------------------------------------------------------
interface cse_in_if;
  logic                               valid;
  logic                               ready;
  logic        [cse_pkg::OP_W-1:0]    op;
  logic        [cse_pkg::IDX_W-1:0]   index;
  logic signed [cse_pkg::DATA_W-1:0]  knot_time;
  logic signed [cse_pkg::DATA_W-1:0]  coef0;
  logic signed [cse_pkg::DATA_W-1:0]  coef1;
  logic signed [cse_pkg::DATA_W-1:0]  coef2;
  logic signed [cse_pkg::DATA_W-1:0]  coef3;
  logic signed [cse_pkg::DATA_W-1:0]  query_time;

  modport source (
    output valid, op, index, knot_time, coef0, coef1, coef2, coef3, query_time,
    input  ready
  );
  modport sink (
    input  valid, op, index, knot_time, coef0, coef1, coef2, coef3, query_time,
    output ready
  );
endinterface

### hdl/cse_out_if.sv
// ----------------------------------------------------------------------------
// cse_out_if - result channel of the spline evaluator
// Valid/ready channel carrying one evaluation result per beat.
// ----------------------------------------------------------------------------
interface cse_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cse_pkg::DATA_W-1:0]  position;
  logic signed [cse_pkg::DATA_W-1:0]  velocity;
  logic signed [cse_pkg::DATA_W-1:0]  acceleration;
  logic        [cse_pkg::IDX_W-1:0]   segment;
  logic                               overflow;

  modport source (
    output valid, position, velocity, acceleration, segment, overflow,
    input  ready
  );
  modport sink (
    input  valid, position, velocity, acceleration, segment, overflow,
    output ready
  );
endinterface

### hdl/cse_mul.sv
// ----------------------------------------------------------------------------
// cse_mul - shared fixed point multiplier
// Signed 64x64 product through one 32x32 slice, four partial products in turn,
// then floor rescale by FRAC_BITS and saturation to signed 64 bits, one job at a time.
// ----------------------------------------------------------------------------
module cse_mul #(
  parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cse_pkg::mul_req_t req,
  output cse_pkg::mul_rsp_t rsp
);

  localparam int PW = cse_pkg::PROD_W;
  localparam int WW = cse_pkg::WIDE_W;
  localparam int HW = cse_pkg::HALF_W;
  localparam logic [PW-1:0] RND = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  cse_pkg::mul_st_t state, state_next;

  logic [WW-1:0]   opa;
  logic [WW-1:0]   opb;
  logic            neg;
  logic [PW-1:0]   acc;
  logic [1:0]      k;
  cse_pkg::mul_rsp_t rsp_q;

  logic [HW-1:0]   half_a;
  logic [HW-1:0]   half_b;
  logic [2*HW-1:0] pp;
  logic [PW-1:0]   pp_sh;
  logic [PW-1:0]   rounded;
  logic            sat_next;
  logic [WW-1:0]   res_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cse_pkg::M_IDLE:  if (req.start) state_next = cse_pkg::M_ABS;
      cse_pkg::M_ABS:   state_next = cse_pkg::M_PP;
      cse_pkg::M_PP:    if (k == 2'd3) state_next = cse_pkg::M_ROUND;
      cse_pkg::M_ROUND: state_next = cse_pkg::M_SAT;
      cse_pkg::M_SAT:   state_next = cse_pkg::M_IDLE;
      default:          state_next = cse_pkg::M_IDLE;
    endcase
  end

  // slice product and placement; k walks a0b0, a1b0, a0b1, a1b1
  always_comb begin
    half_a  = k[0] ? opa[WW-1:HW] : opa[HW-1:0];
    half_b  = k[1] ? opb[WW-1:HW] : opb[HW-1:0];
    pp      = half_a * half_b;
    case (k)
      2'd0:    pp_sh = {{HW{1'b0}}, {HW{1'b0}}, pp};
      2'd1,
      2'd2:    pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
      default: pp_sh = {pp, {HW{1'b0}}, {HW{1'b0}}};
    endcase
    // floor of a negative quotient: bias the magnitude up before the shift
    rounded = acc + (neg ? RND : '0);
  end

  // result formation
  always_comb begin
    if (!neg) begin
      sat_next = (acc[PW-1:WW-1] != '0);
      res_next = sat_next ? cse_pkg::MAX64 : acc[WW-1:0];
    end else begin
      sat_next = (acc[PW-1:WW] != '0) || (acc[WW-1] && (acc[WW-2:0] != '0));
      res_next = sat_next ? cse_pkg::MIN64 : (WW'(0) - acc[WW-1:0]);
    end
  end

  // response record: done pulses the cycle after saturation, with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cse_pkg::M_IDLE;
      rsp_q.done <= 1'b0;
    end else begin
      state      <= state_next;
      rsp_q.done <= (state == cse_pkg::M_SAT);
      if (state == cse_pkg::M_SAT) begin
        rsp_q.sat    <= sat_next;
        rsp_q.result <= res_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cse_pkg::M_IDLE: begin
        if (req.start) begin
          opa <= req.a;
          opb <= req.b;
          neg <= req.a[WW-1] ^ req.b[WW-1];
          acc <= '0;
          k   <= 2'd0;
        end
      end
      cse_pkg::M_ABS: begin
        opa <= opa[WW-1] ? (WW'(0) - opa) : opa;
        opb <= opb[WW-1] ? (WW'(0) - opb) : opb;
      end
      cse_pkg::M_PP: begin
        acc <= acc + pp_sh;
        k   <= k + 2'd1;
      end
      cse_pkg::M_ROUND: acc <= rounded >> FRAC_BITS;
      default: ;
    endcase
  end

  assign rsp = rsp_q;

endmodule

### hdl/cubic_spline_segment_evaluator_top.sv
// ----------------------------------------------------------------------------
// cubic_spline_segment_evaluator_top - piecewise cubic spline evaluator
// Knot and coefficient tables, binary segment search and a shared multiplier
// forming position, velocity and acceleration at a query time.
// ----------------------------------------------------------------------------
// Load the knot times (op 0) and the four Q16.16 coefficients of each segment
// (op 1) before evaluating; the user must write an entry before it is read,
// which the block itself does not enforce, and writes with an index beyond
// the table are dropped. point_count sets the knots in use (clamped to
// 2..MAX_POINTS) and must be written while the block is idle. An evaluate
// beat (op 2) holds the command channel off while it runs: the search reads
// one knot at a time from the knot memory port, then eight products go one
// after another through the single multiplier. Between the end knots the
// search makes at most ceil(log2(n-1)) probes, n being the clamped knot
// count; delivery waits only while the previous result has not yet been
// taken. Results sit in an output register, so table writes are accepted
// while a result waits. Op 3 is a no-op beat.
// ----------------------------------------------------------------------------
module cubic_spline_segment_evaluator_top #(
  parameter int MAX_POINTS = cse_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = cse_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cse_pkg::CNT_W-1:0]  cfg_data,
  cse_in_if.sink                     cmd,
  cse_out_if.source                  res
);

  localparam int AW = $clog2(MAX_POINTS);      // table address
  localparam int NW = $clog2(MAX_POINTS + 1);  // knot count
  localparam int DW = cse_pkg::DATA_W;
  localparam int WW = cse_pkg::WIDE_W;

  cse_pkg::st_t  state, state_next;
  cse_pkg::uop_t uop;

  // configuration
  logic [cse_pkg::CNT_W-1:0] point_count;
  logic [NW-1:0]             n_eff;

  // tables
  logic [DW-1:0]   knot_mem [MAX_POINTS];
  logic [4*DW-1:0] coef_mem [MAX_POINTS];
  logic [AW-1:0]   knot_ra;
  logic signed [DW-1:0] knot_rd;
  logic [4*DW-1:0] coef_rd;
  logic            cmd_ready;
  logic            cmd_acc;
  logic            wr_ok;
  logic [AW-1:0]   wa;

  // search
  logic signed [DW-1:0] q;
  logic [NW-1:0]   n;
  logic [AW-1:0]   lo;
  logic [AW-1:0]   hi;
  logic [AW-1:0]   seg;
  logic [AW:0]     mid_sum;
  logic [AW-1:0]   mid;
  logic [AW-1:0]   lo_new;
  logic [AW-1:0]   hi_new;
  logic [AW-1:0]   span_new;
  logic [AW-1:0]   last_idx;
  logic [AW-1:0]   pen_idx;
  logic            first_hit;
  logic            last_hit;
  logic            probe_le;

  // evaluation
  logic signed [DW-1:0] c0, c1, c2, c3;
  logic [WW-1:0]   tau, t2, t3, pos, vel, acc;
  logic            ov;
  logic [WW-1:0]   c0x, c1x, c2x, c3x, c2x2, c3x3, c3x6;
  logic [WW-1:0]   add_base;
  logic [WW:0]     add_res;
  logic            uop_adds;
  logic            mul_start;
  cse_pkg::mul_req_t mul_req;
  cse_pkg::mul_rsp_t mul_rsp;

  // result register
  logic            out_load;
  logic            out_valid;
  logic [DW:0]     pos_cl, vel_cl, acc_cl;
  logic [DW-1:0]   out_pos, out_vel, out_acc;
  logic [cse_pkg::IDX_W-1:0] out_seg;
  logic            out_ov;

  function automatic logic [WW:0] sat_add(input logic [WW-1:0] a, input logic [WW-1:0] b);
    logic [WW-1:0] s;
    s = a + b;
    if ((a[WW-1] == b[WW-1]) && (s[WW-1] != a[WW-1]))
      return {1'b1, (a[WW-1] ? cse_pkg::MIN64 : cse_pkg::MAX64)};
    return {1'b0, s};
  endfunction

  function automatic logic [DW:0] clamp32(input logic [WW-1:0] v);
    logic fits;
    fits = (v[WW-1:DW-1] == {(WW-DW+1){v[WW-1]}});
    if (fits)
      return {1'b0, v[DW-1:0]};
    return {1'b1, (v[WW-1] ? cse_pkg::MIN32 : cse_pkg::MAX32)};
  endfunction

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= cse_pkg::CNT_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  // out-of-range counts behave as the nearest legal count
  always_comb begin
    if (point_count < cse_pkg::CNT_W'(cse_pkg::MIN_POINTS))
      n_eff = NW'(cse_pkg::MIN_POINTS);
    else if (32'(point_count) > MAX_POINTS)
      n_eff = NW'(MAX_POINTS);
    else
      n_eff = NW'(point_count);
  end

  // ---- search helpers ------------------------------------------------------
  always_comb begin
    mid_sum   = {1'b0, lo} + {1'b0, hi};
    mid       = mid_sum[AW:1];
    probe_le  = (knot_rd <= q);
    lo_new    = probe_le ? mid : lo;
    hi_new    = probe_le ? hi : mid;
    span_new  = hi_new - lo_new;
    last_idx  = AW'(n - NW'(1));
    pen_idx   = AW'(n - NW'(2));
    first_hit = (q <= knot_rd);
    last_hit  = (q >= knot_rd);
  end

  // ---- sequencer: next state -----------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      cse_pkg::ST_IDLE: begin
        if (cmd.valid && (cmd.op == cse_pkg::OP_EVAL)) state_next = cse_pkg::ST_RD_FIRST;
      end
      cse_pkg::ST_RD_FIRST:  state_next = cse_pkg::ST_CMP_FIRST;
      cse_pkg::ST_CMP_FIRST: state_next = first_hit ? cse_pkg::ST_SEG_RD : cse_pkg::ST_RD_LAST;
      cse_pkg::ST_RD_LAST:   state_next = cse_pkg::ST_CMP_LAST;
      cse_pkg::ST_CMP_LAST: begin
        if (last_hit || (last_idx <= AW'(1))) state_next = cse_pkg::ST_SEG_RD;
        else                                  state_next = cse_pkg::ST_PROBE_RD;
      end
      cse_pkg::ST_PROBE_RD:  state_next = cse_pkg::ST_PROBE_CMP;
      cse_pkg::ST_PROBE_CMP: begin
        state_next = (span_new > AW'(1)) ? cse_pkg::ST_PROBE_RD : cse_pkg::ST_SEG_RD;
      end
      cse_pkg::ST_SEG_RD:    state_next = cse_pkg::ST_TAU;
      cse_pkg::ST_TAU:       state_next = cse_pkg::ST_MUL_GO;
      cse_pkg::ST_MUL_GO:    state_next = cse_pkg::ST_MUL_WAIT;
      cse_pkg::ST_MUL_WAIT: begin
        if (mul_rsp.done)
          state_next = (uop == cse_pkg::UOP_A1) ? cse_pkg::ST_DELIVER : cse_pkg::ST_MUL_GO;
      end
      cse_pkg::ST_DELIVER: begin
        if (!out_valid || res.ready) state_next = cse_pkg::ST_IDLE;
      end
      default: state_next = cse_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs --------------------------------------------------
  always_comb begin
    cmd_ready = (state == cse_pkg::ST_IDLE);
    mul_start = (state == cse_pkg::ST_MUL_GO);
    out_load  = (state == cse_pkg::ST_DELIVER) && (!out_valid || res.ready);
    case (state)
      cse_pkg::ST_RD_LAST:  knot_ra = last_idx;
      cse_pkg::ST_PROBE_RD: knot_ra = mid;
      cse_pkg::ST_SEG_RD:   knot_ra = seg;
      default:              knot_ra = '0;
    endcase
  end

  assign cmd.ready = cmd_ready;
  assign cmd_acc   = cmd.valid && cmd_ready;
  assign wr_ok     = (32'(cmd.index) < MAX_POINTS);
  assign wa        = AW'(cmd.index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- tables --------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd_acc && wr_ok && (cmd.op == cse_pkg::OP_WR_KNOT)) begin
      knot_mem[wa] <= cmd.knot_time;
    end
    if (cmd_acc && wr_ok && (cmd.op == cse_pkg::OP_WR_COEF)) begin
      coef_mem[wa] <= {cmd.coef3, cmd.coef2, cmd.coef1, cmd.coef0};
    end
    knot_rd <= knot_mem[knot_ra];
    coef_rd <= coef_mem[seg];
  end

  // ---- operand and accumulate selection ------------------------------------
  always_comb begin
    c0x  = {{(WW-DW){c0[DW-1]}}, c0};
    c1x  = {{(WW-DW){c1[DW-1]}}, c1};
    c2x  = {{(WW-DW){c2[DW-1]}}, c2};
    c3x  = {{(WW-DW){c3[DW-1]}}, c3};
    c2x2 = {c2x[WW-2:0], 1'b0};
    c3x3 = c3x + {c3x[WW-2:0], 1'b0};
    c3x6 = {c3x3[WW-2:0], 1'b0};
    mul_req.start = mul_start;
    case (uop)
      cse_pkg::UOP_T2: begin mul_req.a = tau;  mul_req.b = tau; add_base = '0;  end
      cse_pkg::UOP_T3: begin mul_req.a = t2;   mul_req.b = tau; add_base = '0;  end
      cse_pkg::UOP_P1: begin mul_req.a = c1x;  mul_req.b = tau; add_base = c0x; end
      cse_pkg::UOP_P2: begin mul_req.a = c2x;  mul_req.b = t2;  add_base = pos; end
      cse_pkg::UOP_P3: begin mul_req.a = c3x;  mul_req.b = t3;  add_base = pos; end
      cse_pkg::UOP_V1: begin mul_req.a = c2x2; mul_req.b = tau; add_base = c1x; end
      cse_pkg::UOP_V2: begin mul_req.a = c3x3; mul_req.b = t2;  add_base = vel; end
      default:         begin mul_req.a = c3x6; mul_req.b = tau; add_base = c2x2; end
    endcase
    uop_adds = !((uop == cse_pkg::UOP_T2) || (uop == cse_pkg::UOP_T3));
    add_res  = sat_add(add_base, mul_rsp.result);
  end

  cse_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // ---- datapath registers --------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      cse_pkg::ST_IDLE: begin
        if (cmd_acc) begin
          q <= cmd.query_time;
          n <= n_eff;
        end
      end
      cse_pkg::ST_CMP_FIRST: begin
        if (first_hit) seg <= '0;
      end
      cse_pkg::ST_CMP_LAST: begin
        if (last_hit) begin
          seg <= pen_idx;
        end else begin
          lo  <= '0;
          hi  <= last_idx;
          seg <= '0;
        end
      end
      cse_pkg::ST_PROBE_CMP: begin
        lo  <= lo_new;
        hi  <= hi_new;
        seg <= lo_new;
      end
      cse_pkg::ST_TAU: begin
        // exact difference of two 32-bit times
        tau <= {{(WW-DW){q[DW-1]}}, q} - {{(WW-DW){knot_rd[DW-1]}}, knot_rd};
        c0  <= coef_rd[DW-1:0];
        c1  <= coef_rd[2*DW-1:DW];
        c2  <= coef_rd[3*DW-1:2*DW];
        c3  <= coef_rd[4*DW-1:3*DW];
        ov  <= 1'b0;
        uop <= cse_pkg::UOP_T2;
      end
      cse_pkg::ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          ov <= ov | mul_rsp.sat | (uop_adds & add_res[WW]);
          case (uop)
            cse_pkg::UOP_T2: t2 <= mul_rsp.result;
            cse_pkg::UOP_T3: t3 <= mul_rsp.result;
            cse_pkg::UOP_P1,
            cse_pkg::UOP_P2,
            cse_pkg::UOP_P3: pos <= add_res[WW-1:0];
            cse_pkg::UOP_V1,
            cse_pkg::UOP_V2: vel <= add_res[WW-1:0];
            default:         acc <= add_res[WW-1:0];
          endcase
          uop <= cse_pkg::uop_t'(uop + 3'd1);
        end
      end
      default: ;
    endcase
  end

  // ---- result register -----------------------------------------------------
  always_comb begin
    pos_cl = clamp32(pos);
    vel_cl = clamp32(vel);
    acc_cl = clamp32(acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos <= pos_cl[DW-1:0];
      out_vel <= vel_cl[DW-1:0];
      out_acc <= acc_cl[DW-1:0];
      out_seg <= cse_pkg::IDX_W'(seg);
      out_ov  <= ov | pos_cl[DW] | vel_cl[DW] | acc_cl[DW];
    end
  end

  assign res.valid        = out_valid;
  assign res.position     = out_pos;
  assign res.velocity     = out_vel;
  assign res.acceleration = out_acc;
  assign res.segment      = out_seg;
  assign res.overflow     = out_ov;

endmodule

### tb/sv/tb_cubic_spline_segment_evaluator_top.sv
// ----------------------------------------------------------------------------
// tb_cubic_spline_segment_evaluator_top - self-checking bench for the spline
// evaluator
// Loads knot and coefficient tables, evaluates at chosen query times and
// checks each result beat against a bit-exact Q16.16 predictor kept here,
// under random idling on both channels and several point_count settings.
// ----------------------------------------------------------------------------
module tb_cubic_spline_segment_evaluator_top;
  import cse_pkg::*;

  localparam int MAXP          = DEF_MAX_POINTS;
  localparam int FRAC          = DEF_FRAC_BITS;
  localparam int SETTLE_CYCLES = 100;   // covers the longest evaluation
  localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int MIX_BEATS     = 70;    // mixed beats per phase after loading
  localparam int NUM_PHASES    = 12;

  // op 3 is not in op_t; the block treats it as a no-op beat
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  // point_count per phase: both ends of the range plus values that clamp
  localparam logic [CNT_W-1:0] PHASE_COUNTS [NUM_PHASES] = '{
    7'd64, 7'd2, 7'd9, 7'd0, 7'd127, 7'd33, 7'd1, 7'd64, 7'd65, 7'd17, 7'd40, 7'd64
  };

  typedef struct {
    logic        [OP_W-1:0]   op;
    logic        [IDX_W-1:0]  index;
    logic signed [DATA_W-1:0] knot_time;
    logic signed [DATA_W-1:0] coef0;
    logic signed [DATA_W-1:0] coef1;
    logic signed [DATA_W-1:0] coef2;
    logic signed [DATA_W-1:0] coef3;
    logic signed [DATA_W-1:0] query_time;
    bit                       drain_first; // hold this beat until nothing is due
  } cmd_beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] acceleration;
    logic        [IDX_W-1:0]  segment;
    logic                     overflow;
  } spline_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  cse_in_if  cmd_if ();
  cse_out_if res_if ();

  cubic_spline_segment_evaluator_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd_if),
    .res      (res_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: tables as the block holds them, updated on accepted beats
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] knot_tbl [MAXP];
  logic signed [DATA_W-1:0] coef_tbl [MAXP][4];
  logic        [CNT_W-1:0]  knots_in_use;
  bit                       range_hit;      // any saturation in this evaluation

  spline_result_t spline_results_due [$];
  cmd_beat_t      pending_beats [$];

  // what the stimulus has loaded, so queries can be aimed at the table
  logic signed [DATA_W-1:0] loaded_knots [MAXP];

  int fault_count;
  int quiet_cycles;
  bit cmd_bursts, res_bursts;
  bit beat_offered;   // a command beat is on the bus or about to be
  int cmd_gap, res_gap;
  cmd_beat_t cmd_now;

  // floor(a*b / 2^FRAC), saturated to 64 bits
  function automatic logic signed [WIDE_W-1:0] fx_mul(input logic signed [WIDE_W-1:0] a,
                                                      input logic signed [WIDE_W-1:0] b);
    logic signed [127:0] wa, wb, p, top, bottom;
    wa = a;
    wb = b;
    top = 128'sh7FFF_FFFF_FFFF_FFFF;
    bottom = -top - 128'sd1;
    p = (wa * wb) >>> FRAC;   // arithmetic shift rounds toward minus infinity
    if (p > top) begin
      range_hit = 1'b1;
      return MAX64;
    end
    if (p < bottom) begin
      range_hit = 1'b1;
      return MIN64;
    end
    return p[WIDE_W-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] sat_sum(input logic signed [WIDE_W-1:0] a,
                                                       input logic signed [WIDE_W-1:0] b);
    logic signed [WIDE_W:0] s;
    s = a;
    s = s + b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      range_hit = 1'b1;
      return MAX64;
    end
    if (s < -65'sh0_8000_0000_0000_0000) begin
      range_hit = 1'b1;
      return MIN64;
    end
    return s[WIDE_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_word(input logic signed [WIDE_W-1:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      range_hit = 1'b1;
      return MAX32;
    end
    if (v < -64'sh0000_0000_8000_0000) begin
      range_hit = 1'b1;
      return MIN32;
    end
    return v[DATA_W-1:0];
  endfunction

  // Segment search, tau and the three polynomial results at one query time
  function automatic spline_result_t spline_at(input logic signed [DATA_W-1:0] query);
    int n, lo, hi, mid, seg;
    logic signed [WIDE_W-1:0] q, tau, c0, c1, c2, c3, t2, t3, pos, vel, acc;
    spline_result_t r;
    range_hit = 1'b0;
    n = knots_in_use;
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > MAXP) n = MAXP;
    q = query;
    // end tests first, so unsorted tables still pick an end segment here
    if (q <= knot_tbl[0]) begin
      seg = 0;
    end else if (q >= knot_tbl[n-1]) begin
      seg = n - 2;
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (knot_tbl[mid] <= q) lo = mid;
        else hi = mid;
      end
      seg = lo;
    end
    tau = q - knot_tbl[seg];
    c0 = coef_tbl[seg][0];
    c1 = coef_tbl[seg][1];
    c2 = coef_tbl[seg][2];
    c3 = coef_tbl[seg][3];
    t2 = fx_mul(tau, tau);
    t3 = fx_mul(t2, tau);
    pos = sat_sum(c0, fx_mul(c1, tau));
    pos = sat_sum(pos, fx_mul(c2, t2));
    pos = sat_sum(pos, fx_mul(c3, t3));
    vel = sat_sum(c1, fx_mul(c2 + c2, tau));
    vel = sat_sum(vel, fx_mul(c3 + c3 + c3, t2));
    acc = sat_sum(c2 + c2, fx_mul(64'sd6 * c3, tau));
    r.position     = clamp_word(pos);
    r.velocity     = clamp_word(vel);
    r.acceleration = clamp_word(acc);
    r.segment      = IDX_W'(seg);
    r.overflow     = range_hit;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers: every beat starts fully random so unused fields toggle
  // --------------------------------------------------------------------------
  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    b.op          = OP_W'($urandom);
    b.index       = IDX_W'($urandom);
    b.knot_time   = $urandom;
    b.coef0       = $urandom;
    b.coef1       = $urandom;
    b.coef2       = $urandom;
    b.coef3       = $urandom;
    b.query_time  = $urandom;
    b.drain_first = 1'b0;
    return b;
  endfunction

  task automatic queue_knot(input int idx, input logic signed [DATA_W-1:0] t);
    cmd_beat_t b;
    b = random_beat();
    b.op = OP_WR_KNOT;
    b.index = IDX_W'(idx);
    b.knot_time = t;
    loaded_knots[idx] = t;
    pending_beats.push_back(b);
  endtask

  task automatic queue_coef(input int idx, input logic signed [DATA_W-1:0] c0,
                            input logic signed [DATA_W-1:0] c1,
                            input logic signed [DATA_W-1:0] c2,
                            input logic signed [DATA_W-1:0] c3);
    cmd_beat_t b;
    b = random_beat();
    b.op = OP_WR_COEF;
    b.index = IDX_W'(idx);
    b.coef0 = c0;
    b.coef1 = c1;
    b.coef2 = c2;
    b.coef3 = c3;
    pending_beats.push_back(b);
  endtask

  task automatic queue_eval(input logic signed [DATA_W-1:0] q, input bit drain);
    cmd_beat_t b;
    b = random_beat();
    b.op = OP_EVAL;
    b.query_time = q;
    b.drain_first = drain;
    pending_beats.push_back(b);
  endtask

  task automatic queue_nop();
    cmd_beat_t b;
    b = random_beat();
    b.op = OP_NOP;
    pending_beats.push_back(b);
  endtask

  // mostly modest coefficients so that many results stay in range
  function automatic logic signed [DATA_W-1:0] pick_coef();
    int w;
    w = $urandom_range(0, 99);
    if (w < 50) return int'($urandom) >>> 13;
    if (w < 75) return int'($urandom) >>> 7;
    if (w < 95) return int'($urandom);
    case ($urandom_range(0, 3))
      0: return MAX32;
      1: return MIN32;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // query aimed inside a segment, on a knot, at or past the ends, or anywhere
  function automatic logic signed [DATA_W-1:0] pick_query(input int ne);
    int kind, k;
    longint first_t, last_t, lo_t, hi_t, v;
    kind = $urandom_range(0, 99);
    k = $urandom_range(0, ne - 2);
    lo_t = loaded_knots[k];
    hi_t = loaded_knots[k+1];
    first_t = loaded_knots[0];
    last_t = loaded_knots[ne-1];
    if (kind < 45) begin
      v = (hi_t > lo_t) ? lo_t + $urandom_range(0, 32'(hi_t - lo_t - 1)) : lo_t;
    end else if (kind < 60) begin
      v = loaded_knots[$urandom_range(0, ne - 1)];
    end else if (kind < 70) begin
      v = $urandom_range(0, 1) ? first_t : last_t;
    end else if (kind < 80) begin
      v = $urandom_range(0, 1) ? first_t - $urandom_range(1, 1 << 17)
                               : last_t + $urandom_range(1, 1 << 17);
    end else if (kind < 92) begin
      v = int'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: v = $signed(MIN32);
        1: v = $signed(MAX32);
        2: v = 0;
        default: v = -1;
      endcase
    end
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  // knot layouts: 0 about unit spacing, 1 wide, 2 a few LSBs apart, 3 unsorted
  task automatic load_knots(input int upto, input int style);
    longint t, step_max;
    int i;
    case (style)
      0: step_max = 64'd1 << 17;
      1: step_max = 64'd1 << 25;
      2: step_max = 4;
      default: step_max = 1;
    endcase
    // start low enough that the last knot still fits in 32 bits
    t = -64'sd2147483648 + $urandom_range(0, 32'(64'd4294967295 - (upto - 1) * step_max));
    for (i = 0; i < upto; i++) begin
      if (style == 3) begin
        queue_knot(i, int'($urandom));
      end else begin
        queue_knot(i, 32'(t));
        t += $urandom_range(1, 32'(step_max));
      end
    end
  endtask

  // the block is idle once nothing is queued, offered or due, plus a margin
  // for a trailing write or no-op beat
  task automatic wait_idle();
    while (pending_beats.size() != 0 || beat_offered || spline_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    knots_in_use = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fault_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Command driver: presents queued beats, predicts on each accepted beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
      cmd_gap = 0;
      beat_offered = 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        // accepted beat: tables change now, an evaluation owes one result
        case (cmd_now.op)
          OP_WR_KNOT: knot_tbl[cmd_now.index] = cmd_now.knot_time;
          OP_WR_COEF: begin
            coef_tbl[cmd_now.index][0] = cmd_now.coef0;
            coef_tbl[cmd_now.index][1] = cmd_now.coef1;
            coef_tbl[cmd_now.index][2] = cmd_now.coef2;
            coef_tbl[cmd_now.index][3] = cmd_now.coef3;
          end
          OP_EVAL:    spline_results_due.push_back(spline_at(cmd_now.query_time));
          default: ;  // no-op beat
        endcase
        beat_offered = 1'b0;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_gap > 0) begin
          cmd_gap--;
          cmd_if.valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain_first && spline_results_due.size() != 0)) begin
          cmd_now = pending_beats.pop_front();
          cmd_if.op         <= cmd_now.op;
          cmd_if.index      <= cmd_now.index;
          cmd_if.knot_time  <= cmd_now.knot_time;
          cmd_if.coef0      <= cmd_now.coef0;
          cmd_if.coef1      <= cmd_now.coef1;
          cmd_if.coef2      <= cmd_now.coef2;
          cmd_if.coef3      <= cmd_now.coef3;
          cmd_if.query_time <= cmd_now.query_time;
          cmd_if.valid      <= 1'b1;
          beat_offered = 1'b1;
          // idle burst after this beat goes
          if (cmd_bursts && $urandom_range(0, 5) == 0) cmd_gap = $urandom_range(1, 10);
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random back-pressure, in-order compare with the predictor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    spline_result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      res_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (spline_results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual segment %0d position %h",
                   $time, res_if.segment, res_if.position);
          fault_count++;
        end else begin
          want = spline_results_due.pop_front();
          check_field("position", want.position, res_if.position);
          check_field("velocity", want.velocity, res_if.velocity);
          check_field("acceleration", want.acceleration, res_if.acceleration);
          check_field("segment", want.segment, res_if.segment);
          check_field("overflow", want.overflow, res_if.overflow);
        end
      end
      if (res_gap > 0) begin
        res_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (res_bursts && $urandom_range(0, 5) == 0) res_gap = $urandom_range(1, 10);
      end
    end
  end

  // Watchdog: STALL_LIMIT lies well beyond the slowest evaluation plus a stall and
  // the settle pause, so that many quiet cycles means the block is hung
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, spline_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase, ne, style, j, pick, idx;
    cmd_if.valid      = 1'b0;
    cmd_if.op         = '0;
    cmd_if.index      = '0;
    cmd_if.knot_time  = '0;
    cmd_if.coef0      = '0;
    cmd_if.coef1      = '0;
    cmd_if.coef2      = '0;
    cmd_if.coef3      = '0;
    cmd_if.query_time = '0;
    res_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_data          = '0;
    knots_in_use      = CNT_RESET;
    fault_count       = 0;
    quiet_cycles      = 0;
    cmd_bursts        = 1'b1;
    res_bursts        = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: two knots at the reset point_count, ends and extremes
    queue_knot(0, 32'sh0000_0000);
    queue_knot(1, 32'sh0001_0000);
    queue_coef(0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0000_8000, 32'sh0000_4000);
    queue_eval(32'sh0000_0000, 1'b0);      // exactly on the first knot
    queue_eval(MIN32, 1'b0);               // far before: large negative tau
    queue_eval(32'sh0000_8000, 1'b0);      // inside the segment
    queue_eval(32'sh0001_0000, 1'b0);      // exactly on the last knot
    queue_nop();
    queue_eval(32'sh0001_8000, 1'b0);      // just past the end
    queue_eval(MAX32, 1'b0);               // far past: saturates
    queue_coef(0, MAX32, MIN32, MAX32, MIN32);
    queue_eval(32'sh0000_4000, 1'b0);
    queue_eval(MIN32, 1'b0);
    queue_knot(0, MIN32);                  // widest possible segment
    queue_knot(1, MAX32);
    queue_eval(32'sh0000_0000, 1'b0);
    queue_eval(MAX32, 1'b0);
    queue_eval(MIN32, 1'b0);
    queue_knot(63, MAX32);                 // top table index
    queue_coef(63, MIN32, '0, '1, MAX32);
    queue_coef(0, '0, '0, '0, '0);
    queue_eval(-32'sd1, 1'b0);
    queue_nop();
    wait_idle();

    // Random phases: reload for each point_count, then mostly evaluations
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == NUM_PHASES - 1) begin
        cmd_bursts = 1'b0;   // closing stretch runs flat out
        res_bursts = 1'b0;
      end else begin
        cmd_bursts = (phase % 3 != 2);
        res_bursts = cmd_bursts;
      end
      set_point_count(PHASE_COUNTS[phase]);
      ne = PHASE_COUNTS[phase];
      if (ne < MIN_POINTS) ne = MIN_POINTS;
      if (ne > MAXP) ne = MAXP;
      style = (phase * 3 + 1) % 4;
      if (phase == NUM_PHASES - 1) style = 0;
      // first phase fills every entry so no later read hits an unwritten one
      load_knots((phase == 0) ? MAXP : ne, style);
      for (j = 0; j < ((phase == 0) ? MAXP : ne - 1); j++)
        queue_coef(j, pick_coef(), pick_coef(), pick_coef(), pick_coef());
      for (j = 0; j < MIX_BEATS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          queue_eval(pick_query(ne), $urandom_range(0, 49) == 0);
        end else if (pick < 88) begin
          queue_coef($urandom_range(0, MAXP - 1), pick_coef(), pick_coef(), pick_coef(),
                     pick_coef());
        end else if (pick < 93) begin
          // mostly a harmless rewrite; sometimes a random time that breaks order
          idx = $urandom_range(0, MAXP - 1);
          queue_knot(idx, ($urandom_range(0, 3) == 0) ? int'($urandom) : loaded_knots[idx]);
        end else begin
          queue_nop();
        end
      end
      wait_idle();
    end

    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
